/* hw/rtl/npnl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npnl_pkg
// Shared widths, types and sequencer states of the nearest point normal lookup.
// ----------------------------------------------------------------------------
package npnl_pkg;

   // Table geometry.
   localparam int ENTRIES     = 1024;
   localparam int IDX_BITS    = $clog2(ENTRIES);
   localparam int COUNT_BITS  = 11;

   // Payload formats: Q8.8 positions and Q1.14 normals.
   localparam int COORD_BITS  = 16;
   localparam int NORMAL_BITS = 16;

   // Exact squared distance: one difference, its square and a sum of three.
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int SQ_BITS     = 2 * DIFF_BITS;
   localparam int DIST_BITS   = 2 * COORD_BITS + 4;

   // Request modes.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef logic signed [COORD_BITS-1:0]  coord_type;
   typedef logic signed [NORMAL_BITS-1:0] normal_type;
   typedef logic        [IDX_BITS-1:0]    index_type;
   typedef logic        [COUNT_BITS-1:0]  count_type;
   typedef logic        [DIST_BITS-1:0]   dist_type;

   // Query sequencer.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_LOAD
   } state_type;

endpackage

/* hw/rtl/npnl_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npnl_req_if
// Request channel: entry loads and nearest point queries.
// ----------------------------------------------------------------------------
interface npnl_req_if
   import npnl_pkg::*;
   ;
   logic       valid;
   logic       ready;
   logic       mode;
   index_type  entry_index;
   coord_type  point_x;
   coord_type  point_y;
   coord_type  point_z;
   normal_type load_normal_x;
   normal_type load_normal_y;
   normal_type load_normal_z;
   logic       last_query;

   modport source (
      output valid, mode, entry_index, point_x, point_y, point_z,
             load_normal_x, load_normal_y, load_normal_z, last_query,
      input  ready
   );

   modport sink (
      input  valid, mode, entry_index, point_x, point_y, point_z,
             load_normal_x, load_normal_y, load_normal_z, last_query,
      output ready
   );
endinterface

/* hw/rtl/npnl_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npnl_rsp_if
// Response channel: normal and index of the nearest table entry.
// ----------------------------------------------------------------------------
interface npnl_rsp_if
   import npnl_pkg::*;
   ;
   logic       valid;
   logic       ready;
   normal_type match_normal_x;
   normal_type match_normal_y;
   normal_type match_normal_z;
   index_type  match_index;
   logic       table_empty;
   logic       batch_end;

   modport source (
      output valid, match_normal_x, match_normal_y, match_normal_z,
             match_index, table_empty, batch_end,
      input  ready
   );

   modport sink (
      input  valid, match_normal_x, match_normal_y, match_normal_z,
             match_index, table_empty, batch_end,
      output ready
   );
endinterface

/* hw/rtl/nearest_point_normal_lookup_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_normal_lookup_core
// Brute-force 3D nearest neighbor search over a loaded table of points.
// ----------------------------------------------------------------------------
// A load beat (mode 0) writes one table entry. A query beat (mode 1) scans
// entries 0 to entry_count-1 through one shared distance unit that starts
// one entry per cycle from the position memory. Each entry passes the
// position read, difference, square and sum registers into the running
// minimum; the normal of the winner is then fetched and the result is loaded
// into the response register, after which the request side is ready again.
// With an empty table the query skips the scan and goes straight to that
// last step. While an earlier result is still held by the response side, the
// query waits in its last step and the request side stays not ready.
// Ties go to the lowest index. The result waits in an output register, so a
// new beat is taken while the previous result is still pending. Entries must
// be loaded before a query scans them; entry_count above the table size is
// treated as the full table. Write entry_count only while the block is idle.
// ----------------------------------------------------------------------------
module nearest_point_normal_lookup_core
   import npnl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [COUNT_BITS-1:0] csr_wr_data,
   npnl_req_if.sink          req_bus,
   npnl_rsp_if.source        rsp_bus
);

   // Entry storage: one position word and one normal word per entry.
   logic [3*COORD_BITS-1:0]  pos_mem    [ENTRIES];
   logic [3*NORMAL_BITS-1:0] normal_mem [ENTRIES];

   state_type state_ff, state_in;

   count_type entry_count_ff;
   coord_type qx_ff, qy_ff, qz_ff;
   logic      last_ff;
   logic      empty_ff;
   index_type last_idx_ff;
   index_type rd_addr_ff, rd_addr_in;

   // Distance pipeline.
   logic [3*COORD_BITS-1:0] pos_rd_ff;
   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   index_type               idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic signed [DIFF_BITS-1:0] dx_ff, dy_ff, dz_ff;
   logic [SQ_BITS-1:0]      sx_ff, sy_ff, sz_ff;
   dist_type                sum_ff;

   // Running minimum.
   logic      have_ff;
   dist_type  best_dist_ff;
   index_type best_idx_ff;

   logic [3*NORMAL_BITS-1:0] normal_rd_ff;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   normal_type rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   index_type  rsp_idx_ff;
   logic       rsp_empty_ff, rsp_last_ff;

   // Sequencer outputs.
   logic req_ready;
   logic scan_issue;
   logic rsp_load;

   logic      accept;
   logic      load_wr;
   logic      query_start;
   count_type scan_count;
   logic      pipe_busy;
   logic signed [SQ_BITS-1:0] sq_x, sq_y, sq_z;

   assign accept      = req_bus.valid & req_ready;
   assign load_wr     = accept & (req_bus.mode == MODE_LOAD)
                        & (COUNT_BITS'(req_bus.entry_index) < COUNT_BITS'(ENTRIES));
   assign query_start = accept & (req_bus.mode == MODE_QUERY);
   assign scan_count  = (entry_count_ff > COUNT_BITS'(ENTRIES)) ?
                        COUNT_BITS'(ENTRIES) : entry_count_ff;
   assign pipe_busy   = v1_ff | v2_ff | v3_ff | v4_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_start) begin
               state_in = (scan_count == '0) ? ST_LOAD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_addr_ff == last_idx_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready  = 1'b0;
      scan_issue = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            scan_issue = 1'b1;
         end
         ST_LOAD: begin
            rsp_load = !rsp_valid_ff || rsp_bus.ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_bus.ready = req_ready;
   assign rd_addr_in    = query_start ? '0 : (scan_issue ? rd_addr_ff + 1'b1 : rd_addr_ff);
   assign rsp_valid_in  = rsp_load | (rsp_valid_ff & ~rsp_bus.ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         v4_ff          <= 1'b0;
         have_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            entry_count_ff <= csr_wr_data;
         end
         v1_ff <= scan_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (query_start) begin
            have_ff <= 1'b0;
         end else if (v4_ff) begin
            have_ff <= 1'b1;
         end
      end
   end

   // Entry memories: one write port for loads, registered reads.
   always_ff @(posedge clock) begin
      if (load_wr) begin
         pos_mem[req_bus.entry_index]    <= {req_bus.point_z, req_bus.point_y,
                                             req_bus.point_x};
         normal_mem[req_bus.entry_index] <= {req_bus.load_normal_z,
                                             req_bus.load_normal_y,
                                             req_bus.load_normal_x};
      end
      pos_rd_ff    <= pos_mem[rd_addr_ff];
      normal_rd_ff <= normal_mem[best_idx_ff];
   end

   // Query capture and scan address.
   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      if (query_start) begin
         qx_ff       <= req_bus.point_x;
         qy_ff       <= req_bus.point_y;
         qz_ff       <= req_bus.point_z;
         last_ff     <= req_bus.last_query;
         empty_ff    <= (scan_count == '0);
         last_idx_ff <= IDX_BITS'(scan_count - 1'b1);
      end
   end

   // Distance unit: difference, square, sum, one stage each.
   assign sq_x = dx_ff * dx_ff;
   assign sq_y = dy_ff * dy_ff;
   assign sq_z = dz_ff * dz_ff;

   always_ff @(posedge clock) begin
      idx1_ff <= rd_addr_ff;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      idx4_ff <= idx3_ff;
      dx_ff   <= DIFF_BITS'(qx_ff) - DIFF_BITS'(signed'(pos_rd_ff[COORD_BITS-1:0]));
      dy_ff   <= DIFF_BITS'(qy_ff)
                 - DIFF_BITS'(signed'(pos_rd_ff[2*COORD_BITS-1:COORD_BITS]));
      dz_ff   <= DIFF_BITS'(qz_ff)
                 - DIFF_BITS'(signed'(pos_rd_ff[3*COORD_BITS-1:2*COORD_BITS]));
      sx_ff   <= unsigned'(sq_x);
      sy_ff   <= unsigned'(sq_y);
      sz_ff   <= unsigned'(sq_z);
      sum_ff  <= DIST_BITS'(sx_ff) + DIST_BITS'(sy_ff) + DIST_BITS'(sz_ff);
   end

   // Running minimum: a strict compare keeps the lowest index on ties.
   always_ff @(posedge clock) begin
      if (query_start) begin
         best_idx_ff <= '0;
      end else if (v4_ff && (!have_ff || sum_ff < best_dist_ff)) begin
         best_dist_ff <= sum_ff;
         best_idx_ff  <= idx4_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_nx_ff    <= empty_ff ? '0 : normal_rd_ff[NORMAL_BITS-1:0];
         rsp_ny_ff    <= empty_ff ? '0 : normal_rd_ff[2*NORMAL_BITS-1:NORMAL_BITS];
         rsp_nz_ff    <= empty_ff ? '0 : normal_rd_ff[3*NORMAL_BITS-1:2*NORMAL_BITS];
         rsp_idx_ff   <= empty_ff ? '0 : best_idx_ff;
         rsp_empty_ff <= empty_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.match_normal_x = rsp_nx_ff;
   assign rsp_bus.match_normal_y = rsp_ny_ff;
   assign rsp_bus.match_normal_z = rsp_nz_ff;
   assign rsp_bus.match_index    = rsp_idx_ff;
   assign rsp_bus.table_empty    = rsp_empty_ff;
   assign rsp_bus.batch_end      = rsp_last_ff;

endmodule
